### design/mmsp_pkg.sv
// ----------------------------------------------------------------------------
// mmsp_pkg
// Shared types and constants for the music macro string parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmsp_pkg;

    typedef struct packed {
        logic [6:0]  note_index;
        logic [15:0] duration_ms;
        logic [7:0]  tempo;
        logic [3:0]  volume;
        logic        last;
    } event_t;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0]  OCTAVE_RST  = 3'd4;
    localparam logic [15:0] DEFLEN_RST  = 16'd500;
    localparam logic [7:0]  TEMPO_RST   = 8'd120;
    localparam logic [3:0]  VOLUME_RST  = 4'd3;

    localparam logic [6:0]  KEY_MAX     = 7'd84;
    localparam logic [3:0]  VOL_MAX     = 4'd9;
    localparam logic [7:0]  TEMPO_MIN   = 8'd32;
    localparam logic [2:0]  OCTAVE_MAX  = 3'd6;
    localparam logic [15:0] REST_MS     = 16'd1;

    // whole note of 2000 ms divided by 1..64
    localparam logic [15:0] DIV_TAB [64] = '{
        16'd2000, 16'd1000, 16'd666, 16'd500, 16'd400, 16'd333, 16'd285, 16'd250,
        16'd222,  16'd200,  16'd181, 16'd166, 16'd153, 16'd142, 16'd133, 16'd125,
        16'd117,  16'd111,  16'd105, 16'd100, 16'd95,  16'd90,  16'd86,  16'd83,
        16'd80,   16'd76,   16'd74,  16'd71,  16'd68,  16'd66,  16'd64,  16'd62,
        16'd60,   16'd58,   16'd57,  16'd55,  16'd54,  16'd52,  16'd51,  16'd50,
        16'd48,   16'd47,   16'd46,  16'd45,  16'd44,  16'd43,  16'd42,  16'd41,
        16'd40,   16'd40,   16'd39,  16'd38,  16'd37,  16'd37,  16'd36,  16'd35,
        16'd35,   16'd34,   16'd33,  16'd33,  16'd32,  16'd32,  16'd31,  16'd31
    };

    // key offsets of A..G within an octave
    localparam logic [3:0] LETTER_KEY [7] = '{
        4'd10, 4'd12, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8
    };

endpackage

### design/mmsp_parser.sv
// ----------------------------------------------------------------------------
// mmsp_parser
// Front end: accepts characters, tracks parse state and builds note events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmsp_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_char_code,
    output logic                 push_valid,
    input  logic                 push_ready,
    output mmsp_pkg::event_t     push_ev
);

    localparam logic [2:0] M_IDLE       = 3'd0;
    localparam logic [2:0] M_ARG_FIRST  = 3'd1;
    localparam logic [2:0] M_ARG_DIGITS = 3'd2;
    localparam logic [2:0] M_NOTE_FIRST = 3'd3;
    localparam logic [2:0] M_NOTE_DOTS  = 3'd4;
    localparam logic [2:0] M_SKIP_ONE   = 3'd5;
    localparam logic [2:0] M_SKIP_VAR   = 3'd6;

    localparam logic [2:0] C_NONE  = 3'd0;
    localparam logic [2:0] C_OCT   = 3'd1;
    localparam logic [2:0] C_LEN   = 3'd2;
    localparam logic [2:0] C_PAUSE = 3'd3;
    localparam logic [2:0] C_TEMPO = 3'd4;
    localparam logic [2:0] C_KEY   = 3'd5;
    localparam logic [2:0] C_VOL   = 3'd6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_X     = 8'h58;

    logic [2:0]  octave_reg, octave_next;
    logic [15:0] deflen_reg, deflen_next;
    logic [7:0]  tempo_reg, tempo_next;
    logic [3:0]  volume_reg, volume_next;
    logic [2:0]  mode_reg, mode_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [9:0]  acc_reg, acc_next;
    logic [3:0]  pnote_reg, pnote_next;
    logic [15:0] plen_reg, plen_next;
    logic        hold_valid_reg, hold_valid_next;
    mmsp_pkg::event_t hold_ev_reg, hold_ev_next;

    logic        accept;
    logic [7:0]  c;
    logic        digit;
    logic [3:0]  dval;
    logic [13:0] acc_ext, acc_mul;
    logic [16:0] plen_dot;
    logic [15:0] plen_dot_sat;
    logic [2:0]  oct_clamp;
    logic [5:0]  len_idx;
    logic [15:0] tab_val;
    logic [7:0]  tempo_clamp;
    logic [6:0]  key_clamp;
    logic [3:0]  vol_clamp;
    logic [6:0]  note_sum, note_key;
    logic        is_arg, is_note;

    logic [1:0]  fin_n, n;
    logic [2:0]  oct_a;
    logic [15:0] deflen_a;
    logic [7:0]  tempo_a;
    logic [3:0]  vol_a;
    mmsp_pkg::event_t ev1, ev2;

    logic [2:0]  st_mode, st_cmd, st_oct;
    logic [3:0]  st_pnote;
    logic [15:0] st_plen;

    assign c       = s_char_code;
    assign accept  = s_valid && s_ready;
    assign s_ready = !hold_valid_reg && push_ready;
    assign digit   = (c >= CH_0) && (c <= CH_9);
    assign dval    = c[3:0];

    assign acc_ext  = {4'b0, acc_reg};
    assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + {10'b0, dval};
    assign plen_dot = {1'b0, plen_reg} + {2'b0, plen_reg[15:1]};
    assign plen_dot_sat = plen_dot[16] ? 16'hFFFF : plen_dot[15:0];

    assign oct_clamp   = (acc_reg > 10'(mmsp_pkg::OCTAVE_MAX)) ? mmsp_pkg::OCTAVE_MAX
                                                               : acc_reg[2:0];
    assign len_idx     = (acc_reg == 10'd0) ? 6'd0 :
                         (acc_reg > 10'd64) ? 6'd63 : 6'(acc_reg - 10'd1);
    assign tab_val     = mmsp_pkg::DIV_TAB[len_idx];
    assign tempo_clamp = (acc_reg < 10'(mmsp_pkg::TEMPO_MIN)) ? mmsp_pkg::TEMPO_MIN :
                         (acc_reg > 10'd255) ? 8'd255 : acc_reg[7:0];
    assign key_clamp   = (acc_reg > 10'(mmsp_pkg::KEY_MAX)) ? mmsp_pkg::KEY_MAX
                                                            : acc_reg[6:0];
    assign vol_clamp   = (acc_reg > 10'(mmsp_pkg::VOL_MAX)) ? mmsp_pkg::VOL_MAX
                                                            : acc_reg[3:0];
    assign note_sum    = {3'b0, pnote_reg} + 7'(octave_reg) * 7'd12;
    assign note_key    = (note_sum > mmsp_pkg::KEY_MAX) ? mmsp_pkg::KEY_MAX : note_sum;

    assign is_arg  = (mode_reg == M_ARG_FIRST) || (mode_reg == M_ARG_DIGITS);
    assign is_note = (mode_reg == M_NOTE_FIRST) || (mode_reg == M_NOTE_DOTS);

    // complete the pending command or note
    always_comb begin
        fin_n    = 2'd0;
        oct_a    = octave_reg;
        deflen_a = deflen_reg;
        tempo_a  = tempo_reg;
        vol_a    = volume_reg;
        ev1.note_index  = 7'd0;
        ev1.duration_ms = mmsp_pkg::REST_MS;
        ev1.tempo       = tempo_reg;
        ev1.volume      = 4'd0;
        ev1.last        = 1'b1;
        ev2.note_index  = 7'd0;
        ev2.duration_ms = mmsp_pkg::REST_MS;
        ev2.tempo       = tempo_reg;
        ev2.volume      = 4'd0;
        ev2.last        = 1'b1;
        if (is_arg) begin
            case (cmd_reg)
                C_OCT:   oct_a = oct_clamp;
                C_LEN:   deflen_a = tab_val;
                C_PAUSE: begin
                    fin_n = 2'd1;
                    ev1.duration_ms = tab_val;
                end
                C_TEMPO: tempo_a = tempo_clamp;
                C_KEY: begin
                    fin_n = 2'd1;
                    ev1.note_index  = key_clamp;
                    ev1.duration_ms = deflen_reg;
                    ev1.volume      = volume_reg;
                end
                C_VOL:   vol_a = vol_clamp;
                default: fin_n = 2'd0;
            endcase
        end else if (is_note) begin
            fin_n = 2'd2;
            ev1.note_index  = note_key;
            ev1.duration_ms = plen_reg;
            ev1.volume      = volume_reg;
            ev1.last        = 1'b0;
        end
    end

    // classify the character that opens a new command
    always_comb begin
        st_mode  = M_IDLE;
        st_cmd   = C_NONE;
        st_oct   = oct_a;
        st_pnote = 4'd0;
        st_plen  = 16'd0;
        case (c)
            CH_O: begin
                st_cmd  = C_OCT;
                st_mode = M_ARG_FIRST;
            end
            CH_L: begin
                st_cmd  = C_LEN;
                st_mode = M_ARG_FIRST;
            end
            CH_P: begin
                st_cmd  = C_PAUSE;
                st_mode = M_ARG_FIRST;
            end
            CH_T: begin
                st_cmd  = C_TEMPO;
                st_mode = M_ARG_FIRST;
            end
            CH_N: begin
                st_cmd  = C_KEY;
                st_mode = M_ARG_FIRST;
            end
            CH_V: begin
                st_cmd  = C_VOL;
                st_mode = M_ARG_FIRST;
            end
            CH_LT: begin
                if (oct_a != 3'd0) st_oct = oct_a - 3'd1;
            end
            CH_GT: begin
                if (oct_a < mmsp_pkg::OCTAVE_MAX) st_oct = oct_a + 3'd1;
            end
            CH_M: st_mode = M_SKIP_ONE;
            CH_X: st_mode = M_SKIP_VAR;
            default: begin
                if (c >= CH_A && c <= CH_G) begin
                    st_pnote = mmsp_pkg::LETTER_KEY[3'(c - CH_A)];
                    st_plen  = deflen_a;
                    st_mode  = M_NOTE_FIRST;
                end
            end
        endcase
    end

    always_comb begin
        n           = 2'd0;
        octave_next = octave_reg;
        deflen_next = deflen_reg;
        tempo_next  = tempo_reg;
        volume_next = volume_reg;
        mode_next   = mode_reg;
        cmd_next    = cmd_reg;
        acc_next    = acc_reg;
        pnote_next  = pnote_reg;
        plen_next   = plen_reg;
        if (c == CH_NUL) begin
            n           = fin_n;
            octave_next = mmsp_pkg::OCTAVE_RST;
            deflen_next = mmsp_pkg::DEFLEN_RST;
            tempo_next  = mmsp_pkg::TEMPO_RST;
            volume_next = mmsp_pkg::VOLUME_RST;
            mode_next   = M_IDLE;
            cmd_next    = C_NONE;
            acc_next    = 10'd0;
            pnote_next  = 4'd0;
            plen_next   = 16'd0;
        end else begin
            case (mode_reg)
                M_SKIP_ONE: mode_next = M_IDLE;
                M_SKIP_VAR: begin
                    if (c == CH_SEMI) mode_next = M_IDLE;
                end
                M_ARG_FIRST: begin
                    if (c == CH_EQ) begin
                        n           = fin_n;
                        octave_next = oct_a;
                        deflen_next = deflen_a;
                        tempo_next  = tempo_a;
                        volume_next = vol_a;
                        mode_next   = M_SKIP_VAR;
                        cmd_next    = C_NONE;
                        acc_next    = 10'd0;
                        pnote_next  = 4'd0;
                        plen_next   = 16'd0;
                    end else if (digit) begin
                        acc_next  = {6'b0, dval};
                        mode_next = M_ARG_DIGITS;
                    end else begin
                        n           = fin_n;
                        octave_next = st_oct;
                        deflen_next = deflen_a;
                        tempo_next  = tempo_a;
                        volume_next = vol_a;
                        mode_next   = st_mode;
                        cmd_next    = st_cmd;
                        acc_next    = 10'd0;
                        pnote_next  = st_pnote;
                        plen_next   = st_plen;
                    end
                end
                M_ARG_DIGITS: begin
                    if (digit) begin
                        acc_next = (acc_mul > 14'd1023) ? 10'd1023 : acc_mul[9:0];
                    end else begin
                        n           = fin_n;
                        octave_next = st_oct;
                        deflen_next = deflen_a;
                        tempo_next  = tempo_a;
                        volume_next = vol_a;
                        mode_next   = st_mode;
                        cmd_next    = st_cmd;
                        acc_next    = 10'd0;
                        pnote_next  = st_pnote;
                        plen_next   = st_plen;
                    end
                end
                M_NOTE_FIRST: begin
                    if (c == CH_HASH || c == CH_PLUS) begin
                        pnote_next = pnote_reg + 4'd1;
                        mode_next  = M_NOTE_DOTS;
                    end else if (c == CH_MINUS) begin
                        if (pnote_reg != 4'd0) pnote_next = pnote_reg - 4'd1;
                        mode_next = M_NOTE_DOTS;
                    end else if (c == CH_DOT) begin
                        plen_next = plen_dot_sat;
                        mode_next = M_NOTE_DOTS;
                    end else begin
                        n           = fin_n;
                        octave_next = st_oct;
                        deflen_next = deflen_a;
                        tempo_next  = tempo_a;
                        volume_next = vol_a;
                        mode_next   = st_mode;
                        cmd_next    = st_cmd;
                        acc_next    = 10'd0;
                        pnote_next  = st_pnote;
                        plen_next   = st_plen;
                    end
                end
                M_NOTE_DOTS: begin
                    if (c == CH_DOT) begin
                        plen_next = plen_dot_sat;
                    end else begin
                        n           = fin_n;
                        octave_next = st_oct;
                        deflen_next = deflen_a;
                        tempo_next  = tempo_a;
                        volume_next = vol_a;
                        mode_next   = st_mode;
                        cmd_next    = st_cmd;
                        acc_next    = 10'd0;
                        pnote_next  = st_pnote;
                        plen_next   = st_plen;
                    end
                end
                default: begin
                    octave_next = st_oct;
                    mode_next   = st_mode;
                    cmd_next    = st_cmd;
                    acc_next    = 10'd0;
                    pnote_next  = st_pnote;
                    plen_next   = st_plen;
                end
            endcase
        end
    end

    // first event goes straight to the queue, the trailing rest is held until taken
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_ev_next    = hold_ev_reg;
        push_valid      = 1'b0;
        push_ev         = ev1;
        if (hold_valid_reg) begin
            push_valid = 1'b1;
            push_ev    = hold_ev_reg;
            if (push_ready) hold_valid_next = 1'b0;
        end else if (accept && n != 2'd0) begin
            push_valid = 1'b1;
            if (n == 2'd2) begin
                hold_valid_next = 1'b1;
                hold_ev_next    = ev2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octave_reg     <= mmsp_pkg::OCTAVE_RST;
            deflen_reg     <= mmsp_pkg::DEFLEN_RST;
            tempo_reg      <= mmsp_pkg::TEMPO_RST;
            volume_reg     <= mmsp_pkg::VOLUME_RST;
            mode_reg       <= M_IDLE;
            cmd_reg        <= C_NONE;
            acc_reg        <= 10'd0;
            pnote_reg      <= 4'd0;
            plen_reg       <= 16'd0;
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            if (accept) begin
                octave_reg <= octave_next;
                deflen_reg <= deflen_next;
                tempo_reg  <= tempo_next;
                volume_reg <= volume_next;
                mode_reg   <= mode_next;
                cmd_reg    <= cmd_next;
                acc_reg    <= acc_next;
                pnote_reg  <= pnote_next;
                plen_reg   <= plen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hold_ev_reg <= hold_ev_next;
    end

endmodule

### design/mmsp_queue.sv
// ----------------------------------------------------------------------------
// mmsp_queue
// Short event queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmsp_queue #(
    parameter int DEPTH = mmsp_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  mmsp_pkg::event_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output mmsp_pkg::event_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mmsp_pkg::event_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) store_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### design/mmsp_out_stage.sv
// ----------------------------------------------------------------------------
// mmsp_out_stage
// Back end: pops queued events into the registered result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmsp_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mmsp_pkg::event_t in_ev,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [6:0]       m_note_index,
    output logic [15:0]      m_duration_ms,
    output logic [7:0]       m_tempo,
    output logic [3:0]       m_volume,
    output logic             m_last
);

    logic             out_valid_reg, out_valid_next;
    mmsp_pkg::event_t out_ev_reg;

    assign in_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_ready) out_valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) out_ev_reg <= in_ev;
    end

    assign m_valid       = out_valid_reg;
    assign m_note_index  = out_ev_reg.note_index;
    assign m_duration_ms = out_ev_reg.duration_ms;
    assign m_tempo       = out_ev_reg.tempo;
    assign m_volume      = out_ev_reg.volume;
    assign m_last        = out_ev_reg.last;

endmodule

### design/music_macro_string_parser_core.sv
// ----------------------------------------------------------------------------
// music_macro_string_parser_core
// Path: an accepted character's first event is queued, then registered in the
// output stage. Throughput: 1 character per cycle while the queue has room;
// one event is pushed per cycle; s_ready drops while a note's rest is held.
// Reset: synchronous, active low; restores octave 4, length 500 ms, tempo 120,
// volume 3, idle parser, empty queue and no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module music_macro_string_parser_core #(
    parameter int QUEUE_DEPTH = mmsp_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_note_index,
    output logic [15:0] m_duration_ms,
    output logic [7:0]  m_tempo,
    output logic [3:0]  m_volume,
    output logic        m_last
);

    logic             push_valid, push_ready;
    mmsp_pkg::event_t push_ev;
    logic             pop_valid, pop_ready;
    mmsp_pkg::event_t pop_ev;

    mmsp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_ev     (push_ev)
    );

    mmsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_ev),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_ev)
    );

    mmsp_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (pop_valid),
        .in_ready      (pop_ready),
        .in_ev         (pop_ev),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_note_index  (m_note_index),
        .m_duration_ms (m_duration_ms),
        .m_tempo       (m_tempo),
        .m_volume      (m_volume),
        .m_last        (m_last)
    );

endmodule

### design/mmsp_checker.sv
// ----------------------------------------------------------------------------
// mmsp_checker
// Port-level checks on the result channel of the parser core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [6:0]  m_note_index,
    input logic [15:0] m_duration_ms,
    input logic [7:0]  m_tempo,
    input logic [3:0]  m_volume,
    input logic        m_last
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_note_index)
            && $stable(m_duration_ms) && $stable(m_last))
        else $error("stalled item changed");

    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_note_index <= mmsp_pkg::KEY_MAX && m_volume <= mmsp_pkg::VOL_MAX
            && m_tempo >= mmsp_pkg::TEMPO_MIN && m_duration_ms != 16'd0)
        else $error("result field out of range");

    a_rest_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_last
            && m_note_index == 7'd0 && m_volume == 4'd0
            && m_duration_ms == mmsp_pkg::REST_MS)
        else $error("note not followed by its silent rest");

endmodule

bind music_macro_string_parser_core mmsp_checker u_mmsp_checker (.*);
